// File: hw/rtl/gcr_six_and_two_sector_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the six-and-two sector encoder
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GCR_SIX_AND_TWO_SECTOR_ENCODER_UNIT_MACROS_SVH
`define GCR_SIX_AND_TWO_SECTOR_ENCODER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCR62_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCR62_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gcr62_pkg.sv
// ----------------------------------------------------------------------------
// gcr62_pkg
// Shared types, constants and the 6-bit to disk nibble write table.
// ----------------------------------------------------------------------------
package gcr62_pkg;

    localparam logic [8:0] SECTOR_BYTES = 9'd256;
    localparam logic [8:0] AUX_COUNT    = 9'd86;
    localparam logic [8:0] LAST_NIBBLE  = 9'd342;

    // Auxiliary lane layout: bytes 0..85, 86..171, 172..255 feed lanes 0, 1, 2;
    // bytes 0 and 1 also wrap into lane 2 entries 84 and 85.
    localparam int unsigned LANE_DEPTH = 86;
    localparam int unsigned LANE_AW    = $clog2(LANE_DEPTH);
    localparam logic [7:0]  LANE1_BASE = 8'd86;
    localparam logic [7:0]  LANE2_BASE = 8'd172;
    localparam logic [LANE_AW-1:0] WRAP_BASE = LANE_AW'(84);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_AUX,
        CMD_DATA,
        CMD_LAST
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] addr;
        logic [7:0] data;
    } cmd_t;

    localparam logic [7:0] WRITE_TABLE [64] = '{
        8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
        8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
        8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
        8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
        8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
        8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
        8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
        8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
    };

endpackage

// File: hw/rtl/gcr62_front.sv
// ----------------------------------------------------------------------------
// gcr62_front
// Classifies incoming transactions, tracks sector fill and nibble position,
// and emits commands for the back end.
// ----------------------------------------------------------------------------
`include "gcr_six_and_two_sector_encoder_unit_macros.svh"

module gcr62_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              op,
    input  logic [7:0]        data_byte,
    output logic              push,
    output gcr62_pkg::cmd_t   cmd
);

    logic [8:0] bytes_loaded_reg, bytes_loaded_next;
    logic [8:0] nibble_index_reg, nibble_index_next;
    logic       sector_full;
    logic [8:0] data_offset;

    assign sector_full = (bytes_loaded_reg == gcr62_pkg::SECTOR_BYTES);
    assign data_offset = nibble_index_reg - gcr62_pkg::AUX_COUNT;

    always_comb
    begin
        bytes_loaded_next = bytes_loaded_reg;
        nibble_index_next = nibble_index_reg;
        push              = 1'b0;
        cmd.kind          = gcr62_pkg::CMD_LOAD;
        cmd.addr          = bytes_loaded_reg[7:0];
        cmd.data          = data_byte;
        if (accept)
        begin
            if (!op)
            begin
                // drop loads into a full sector
                if (!sector_full)
                begin
                    push              = 1'b1;
                    bytes_loaded_next = bytes_loaded_reg + 9'd1;
                end
            end
            else if (sector_full)
            begin
                push = 1'b1;
                if (nibble_index_reg == gcr62_pkg::LAST_NIBBLE)
                begin
                    cmd.kind          = gcr62_pkg::CMD_LAST;
                    cmd.addr          = 8'd0;
                    bytes_loaded_next = 9'd0;
                    nibble_index_next = 9'd0;
                end
                else
                begin
                    if (nibble_index_reg < gcr62_pkg::AUX_COUNT)
                    begin
                        cmd.kind = gcr62_pkg::CMD_AUX;
                        cmd.addr = nibble_index_reg[7:0];
                    end
                    else
                    begin
                        cmd.kind = gcr62_pkg::CMD_DATA;
                        cmd.addr = data_offset[7:0];
                    end
                    nibble_index_next = nibble_index_reg + 9'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_loaded_reg <= 9'd0;
            nibble_index_reg <= 9'd0;
        end
        else
        begin
            bytes_loaded_reg <= bytes_loaded_next;
            nibble_index_reg <= nibble_index_next;
        end
    end

    `GCR62_ASSERT_SAME(a_index_needs_full_sector, nibble_index_reg != 9'd0, sector_full,
        "nibble position advanced without a full sector")
    `GCR62_ASSERT_NEXT(a_last_rearms_sector, push && cmd.kind == gcr62_pkg::CMD_LAST,
        bytes_loaded_reg == 9'd0 && nibble_index_reg == 9'd0,
        "sector not rearmed after final nibble")

endmodule

// File: hw/rtl/gcr62_fifo.sv
// ----------------------------------------------------------------------------
// gcr62_fifo
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
`include "gcr_six_and_two_sector_encoder_unit_macros.svh"

module gcr62_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gcr62_pkg::cmd_t   push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output gcr62_pkg::cmd_t   head
);

    gcr62_pkg::cmd_t entries [gcr62_pkg::QUEUE_DEPTH];

    logic [gcr62_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [gcr62_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [gcr62_pkg::QUEUE_CW-1:0] count_reg, count_next;

    localparam logic [gcr62_pkg::QUEUE_AW-1:0] PTR_LAST =
        gcr62_pkg::QUEUE_AW'(gcr62_pkg::QUEUE_DEPTH - 1);
    localparam logic [gcr62_pkg::QUEUE_CW-1:0] COUNT_FULL =
        gcr62_pkg::QUEUE_CW'(gcr62_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == COUNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `GCR62_ASSERT_SAME(a_no_overflow, push, !full || pop, "push into full queue")
    `GCR62_ASSERT_SAME(a_no_underflow, pop, not_empty, "pop from empty queue")

endmodule

// File: hw/rtl/gcr62_back.sv
// ----------------------------------------------------------------------------
// gcr62_back
// Executes queued commands: stores sector bytes, reads the stored values,
// chains each value with the previous one and maps it to a disk nibble.
// ----------------------------------------------------------------------------
`include "gcr_six_and_two_sector_encoder_unit_macros.svh"

module gcr62_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  gcr62_pkg::cmd_t   head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        nibble,
    output logic              last
);

    localparam int unsigned LAW = gcr62_pkg::LANE_AW;

    // high six bits of every byte, and the bit-swapped low pair in three lanes
    logic [5:0] hi_mem    [256];
    logic [1:0] lane0_mem [gcr62_pkg::LANE_DEPTH];
    logic [1:0] lane1_mem [gcr62_pkg::LANE_DEPTH];
    logic [1:0] lane2_mem [gcr62_pkg::LANE_DEPTH];

    logic [5:0] hi_q;
    logic [1:0] lane0_q, lane1_q, lane2_q;

    logic                   rd_valid_reg, rd_valid_next;
    gcr62_pkg::cmd_kind_t   rd_kind_reg;
    logic [5:0]             prev_reg, prev_next;
    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_nibble_reg;
    logic                   out_last_reg;

    logic       out_free, st2_go, st2_free;
    logic       is_load, is_req;
    logic [1:0] swapped;
    logic       lane0_we, lane1_we, lane2_we;
    logic [7:0] lane1_off, lane2_off;
    logic [LAW-1:0] lane1_waddr, lane2_waddr;
    logic [5:0] value;
    logic [5:0] chained;

    assign out_free = !out_valid_reg || out_ready;
    assign st2_go   = rd_valid_reg && out_free;
    assign st2_free = !rd_valid_reg || out_free;
    assign is_load  = head_valid && (head.kind == gcr62_pkg::CMD_LOAD);
    assign is_req   = head_valid && (head.kind != gcr62_pkg::CMD_LOAD) && st2_free;
    assign pop      = is_load || is_req;

    // ---- load path: lane selection ----
    assign swapped   = {head.data[0], head.data[1]};
    assign lane1_off = head.addr - gcr62_pkg::LANE1_BASE;
    assign lane2_off = head.addr - gcr62_pkg::LANE2_BASE;

    always_comb
    begin
        lane0_we    = 1'b0;
        lane1_we    = 1'b0;
        lane2_we    = 1'b0;
        lane1_waddr = lane1_off[LAW-1:0];
        lane2_waddr = lane2_off[LAW-1:0];
        if (is_load)
        begin
            if (head.addr < gcr62_pkg::LANE1_BASE)
            begin
                lane0_we = 1'b1;
                // bytes 0 and 1 also fill the top pair of the last two entries
                if (head.addr < 8'd2)
                begin
                    lane2_we    = 1'b1;
                    lane2_waddr = gcr62_pkg::WRAP_BASE + LAW'(head.addr[0]);
                end
            end
            else if (head.addr < gcr62_pkg::LANE2_BASE)
            begin
                lane1_we = 1'b1;
            end
            else
            begin
                lane2_we = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            hi_mem[head.addr] <= head.data[7:2];
        end
        if (is_req && head.kind == gcr62_pkg::CMD_DATA)
        begin
            hi_q <= hi_mem[head.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane0_we)
        begin
            lane0_mem[head.addr[LAW-1:0]] <= swapped;
        end
        if (is_req && head.kind == gcr62_pkg::CMD_AUX)
        begin
            lane0_q <= lane0_mem[head.addr[LAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane1_we)
        begin
            lane1_mem[lane1_waddr] <= swapped;
        end
        if (is_req && head.kind == gcr62_pkg::CMD_AUX)
        begin
            lane1_q <= lane1_mem[head.addr[LAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane2_we)
        begin
            lane2_mem[lane2_waddr] <= swapped;
        end
        if (is_req && head.kind == gcr62_pkg::CMD_AUX)
        begin
            lane2_q <= lane2_mem[head.addr[LAW-1:0]];
        end
    end

    // ---- value stage ----
    always_comb
    begin
        unique case (rd_kind_reg)
            gcr62_pkg::CMD_AUX:  value = {lane2_q, lane1_q, lane0_q};
            gcr62_pkg::CMD_DATA: value = hi_q;
            default:             value = 6'd0;
        endcase
    end

    // final nibble maps the previous value itself, so chain against zero
    assign chained = value ^ prev_reg;

    always_comb
    begin
        rd_valid_next  = rd_valid_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg;
        if (st2_go)
        begin
            rd_valid_next  = 1'b0;
            prev_next      = value;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (is_req)
        begin
            rd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_req)
        begin
            rd_kind_reg <= head.kind;
        end
        if (st2_go)
        begin
            out_nibble_reg <= gcr62_pkg::WRITE_TABLE[chained];
            out_last_reg   <= (rd_kind_reg == gcr62_pkg::CMD_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            prev_reg      <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign nibble    = out_nibble_reg;
    assign last      = out_last_reg;

    `GCR62_ASSERT_SAME(a_last_clears_chain, out_valid_reg && out_last_reg, prev_reg == 6'd0,
        "chain not cleared after final nibble")
    `GCR62_ASSERT_NEXT(a_read_lands, is_req, rd_valid_reg, "issued read lost")

endmodule

// File: hw/rtl/gcr_six_and_two_sector_encoder_unit.sv
// Throughput: one transaction per cycle while the queue is not full; loads and
// requests share the input. The rate is set by the one-port sector memories read
// once per request.
// Reset (rst_n low, asynchronous) empties the queue and pipeline, clears the
// fill count, nibble position and chain value; stored bytes are kept.
// ----------------------------------------------------------------------------
// gcr_six_and_two_sector_encoder_unit
// Six-and-two GCR encoder for the data field of one 256-byte disk sector.
// ----------------------------------------------------------------------------
module gcr_six_and_two_sector_encoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] op
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] nibble
    output logic       m_axis_tlast
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            full;
    logic            head_valid;
    gcr62_pkg::cmd_t cmd;
    gcr62_pkg::cmd_t head;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    gcr62_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .push      (push),
        .cmd       (cmd)
    );

    gcr62_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (head_valid),
        .head      (head)
    );

    gcr62_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .nibble     (m_axis_tdata),
        .last       (m_axis_tlast)
    );

endmodule
